/* design/sed_pkg.sv */
// shared types, codes and the letter escape table for the string escape decoder
package sed_pkg;

   // decoder mode
   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_ESCAPE,
      MODE_DECIMAL,
      MODE_ERROR
   } mode_type;

   // status codes reported on the final result of a string
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_ESCAPE = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW   = 2'd2;

   // ascii codes used by the decoder
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   // largest decimal escape value that fits a byte
   localparam logic [11:0] BYTE_MAX = 12'd255;

   // input transaction
   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_string;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [7:0] char_out;
      logic       char_valid;
      logic [1:0] status;
      logic       string_done;
      logic       run_last;
   } rsp_type;

   // up to two results caused by one input transaction
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } pair_type;

   // letter escape lookup: bit 8 set when the letter is a known escape
   function automatic logic [8:0] letter_escape(input logic [7:0] ch);
      logic [8:0] code;
      unique case (ch)
         8'h5C:   code = {1'b1, 8'd92};  // backslash
         8'h6E:   code = {1'b1, 8'd10};  // n
         8'h74:   code = {1'b1, 8'd9};   // t
         8'h72:   code = {1'b1, 8'd13};  // r
         8'h62:   code = {1'b1, 8'd8};   // b
         8'h66:   code = {1'b1, 8'd12};  // f
         8'h76:   code = {1'b1, 8'd11};  // v
         8'h61:   code = {1'b1, 8'd7};   // a
         8'h27:   code = {1'b1, 8'd39};  // single quote
         8'h22:   code = {1'b1, 8'd34};  // double quote
         default: code = 9'd0;
      endcase
      return code;
   endfunction

   // build one result
   function automatic rsp_type make_rsp(input logic [7:0] ch, input logic valid,
                                        input logic [1:0] st, input logic done);
      rsp_type r;
      r.char_out    = ch;
      r.char_valid  = valid;
      r.status      = st;
      r.string_done = done;
      r.run_last    = 1'b0;
      return r;
   endfunction

endpackage

/* design/sed_decode.sv */
// escape decoding state machine: mode state plus the per-byte result logic
module sed_decode #(
   parameter int MAX_DIGITS = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  sed_pkg::req_type  item,
   output sed_pkg::pair_type pair
);
   import sed_pkg::*;

   localparam logic [1:0] DigitLimit = 2'(MAX_DIGITS);

   mode_type    mode_ff, mode_in;
   logic [7:0]  dval_ff, dval_in;
   logic [1:0]  dcnt_ff, dcnt_in;
   logic [1:0]  err_ff, err_in;

   logic        is_digit;
   logic [7:0]  digit;
   logic [11:0] value;
   logic [8:0]  esc;
   logic        plain;
   logic [1:0]  n;
   rsp_type     res [2];

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         dval_ff <= '0;
         dcnt_ff <= '0;
         err_ff  <= STATUS_OK;
      end else if (advance) begin
         mode_ff <= mode_in;
         dval_ff <= dval_in;
         dcnt_ff <= dcnt_in;
         err_ff  <= err_in;
      end
   end

   // next state and results for the current byte
   always_comb begin
      mode_in  = mode_ff;
      dval_in  = dval_ff;
      dcnt_in  = dcnt_ff;
      err_in   = err_ff;
      plain    = 1'b0;
      n        = 2'd0;
      res[0]   = '0;
      res[1]   = '0;
      is_digit = (item.char_in >= CHAR_ZERO) && (item.char_in <= CHAR_NINE);
      digit    = item.char_in - CHAR_ZERO;
      value    = {1'b0, dval_ff, 3'b000} + {3'b000, dval_ff, 1'b0} + {4'd0, digit};
      esc      = letter_escape(item.char_in);

      unique case (mode_ff)
         MODE_NORMAL: begin
            plain = 1'b1;
         end
         MODE_ESCAPE: begin
            if (is_digit) begin
               dval_in = digit;
               dcnt_in = 2'd1;
               mode_in = MODE_DECIMAL;
               if (2'd1 >= DigitLimit) begin
                  res[n[0]] = make_rsp(digit, 1'b1, STATUS_OK, 1'b0);
                  n         = n + 2'd1;
                  mode_in   = MODE_NORMAL;
                  dcnt_in   = 2'd0;
               end
            end else if (esc[8]) begin
               res[n[0]] = make_rsp(esc[7:0], 1'b1, STATUS_OK, 1'b0);
               n         = n + 2'd1;
               mode_in   = MODE_NORMAL;
            end else begin
               mode_in = MODE_ERROR;
               err_in  = STATUS_BAD_ESCAPE;
            end
         end
         MODE_DECIMAL: begin
            if (is_digit) begin
               if (value > BYTE_MAX) begin
                  mode_in = MODE_ERROR;
                  err_in  = STATUS_OVERFLOW;
               end else begin
                  dval_in = value[7:0];
                  dcnt_in = dcnt_ff + 2'd1;
                  if (dcnt_in >= DigitLimit) begin
                     res[n[0]] = make_rsp(value[7:0], 1'b1, STATUS_OK, 1'b0);
                     n         = n + 2'd1;
                     mode_in   = MODE_NORMAL;
                     dcnt_in   = 2'd0;
                  end
               end
            end else begin
               // pending decimal byte first, then the ending byte as plain text
               res[n[0]] = make_rsp(dval_ff, 1'b1, STATUS_OK, 1'b0);
               n         = n + 2'd1;
               mode_in   = MODE_NORMAL;
               dcnt_in   = 2'd0;
               plain     = 1'b1;
            end
         end
         MODE_ERROR: begin
            plain = 1'b0;
         end
         default: begin
            plain = 1'b0;
         end
      endcase

      // ordinary byte
      if (plain) begin
         if (item.char_in == CHAR_BACKSLASH) begin
            mode_in = MODE_ESCAPE;
         end else if (n != 2'd2) begin
            res[n[0]] = make_rsp(item.char_in, 1'b1, STATUS_OK, 1'b0);
            n         = n + 2'd1;
         end
      end

      // end of string: close out and return to reset state
      if (item.end_of_string) begin
         if (mode_in == MODE_DECIMAL) begin
            if (n != 2'd2) begin
               res[n[0]] = make_rsp(dval_in, 1'b1, STATUS_OK, 1'b1);
               n         = n + 2'd1;
            end
         end else if (mode_in == MODE_ESCAPE) begin
            if (n != 2'd2) begin
               res[n[0]] = make_rsp(8'd0, 1'b0, STATUS_BAD_ESCAPE, 1'b1);
               n         = n + 2'd1;
            end
         end else if (mode_in == MODE_ERROR) begin
            if (n != 2'd2) begin
               res[n[0]] = make_rsp(8'd0, 1'b0, err_in, 1'b1);
               n         = n + 2'd1;
            end
         end else if (n == 2'd0) begin
            res[0] = make_rsp(8'd0, 1'b0, STATUS_OK, 1'b1);
            n      = 2'd1;
         end else begin
            res[~n[0]].string_done = 1'b1;
         end
         mode_in = MODE_NORMAL;
         dval_in = '0;
         dcnt_in = '0;
         err_in  = STATUS_OK;
      end

      // mark the last result of this byte
      if (n != 2'd0) begin
         res[~n[0]].run_last = 1'b1;
      end

      pair.count  = n;
      pair.first  = res[0];
      pair.second = res[1];
   end

endmodule

/* design/string_escape_decoder.sv */
// top level of the string escape decoder: input register, decoder, result buffer
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | sed_pkg::req_type (char_in, end_of_string)
//   rsp     | out       | rsp_valid/rsp_stall | sed_pkg::rsp_type (char_out .. run_last)
//
// one input byte per cycle while results are not stalled; a two-result byte stalls the input
// from input acceptance to first result a byte passes the input register and the result buffer
// the result buffer takes a decoded byte when empty or when its one entry leaves that cycle
// synchronous active-high reset clears the mode state and both handshake stages
// a stalled result holds its payload while the input register can still take one byte
module string_escape_decoder #(
   parameter int MAX_DIGITS = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sed_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sed_pkg::rsp_type rsp_data
);
   import sed_pkg::*;

   req_type    item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;

   pair_type   pair;
   logic       pop;
   logic       move;
   logic       take;

   // decoder
   sed_decode #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (move),
      .item    (item_ff),
      .pair    (pair)
   );

   // handshake control
   assign pop       = (count_ff != 2'd0) && !rsp_stall;
   assign move      = item_valid_ff && ((count_ff == 2'd0) || ((count_ff == 2'd1) && pop));
   assign req_stall = item_valid_ff && !move;
   assign take      = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;

   // next values of input register and result buffer
   always_comb begin
      item_in       = take ? req_data : item_ff;
      item_valid_in = take ? 1'b1 : (move ? 1'b0 : item_valid_ff);
      slot0_in      = slot0_ff;
      slot1_in      = slot1_ff;
      count_in      = count_ff;
      if (move) begin
         slot0_in = pair.first;
         slot1_in = pair.second;
         count_in = pair.count;
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         count_ff      <= 2'd0;
      end else begin
         item_valid_ff <= item_valid_in;
         count_ff      <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

`ifndef SYNTH
   // buffer never holds more than two results
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer over two entries");

   // input only stalls while a byte waits in the input register
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid_ff)
      else $error("input stalled with empty input register");

   // a full buffer that delivers drops to one entry without a new load
   a_full_drain: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) && !rsp_stall |=> count_ff == 2'd1)
      else $error("full buffer did not drain by one");

   // the second buffered result moves to the head after delivery
   a_shift: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) && !rsp_stall |=> rsp_data == $past(slot1_ff))
      else $error("second result not shifted to head");
`endif

endmodule

/* sim/tb.sv */
// self-checking testbench for the string escape decoder
module tb;
   import sed_pkg::*;

   localparam int MAX_DIGITS       = 3;
   localparam int LONG_HOLD_CYCLES = 300;

   // letters that form a valid escape after a backslash
   localparam logic [7:0] ESC_LETTERS [10] = '{"\\", "n", "t", "r", "b", "f", "v", "a", "'", "\""};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   // bytes waiting to be driven and decoded bytes still to arrive
   req_type pending_bytes [$];
   rsp_type expected_chars [$];
   rsp_type step_results [$];

   // decoder state mirrored by the testbench
   mode_type   dec_mode   = MODE_NORMAL;
   logic [7:0] dec_value  = '0;
   logic [1:0] dec_digits = '0;
   logic [1:0] dec_error  = STATUS_OK;

   // traffic shaping
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic long_hold      = 1'b0;
   int   hold_count     = 0;
   int   errors         = 0;

   string_escape_decoder #(.MAX_DIGITS(MAX_DIGITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // byte a letter escape stands for, -1 when the letter is not an escape
   function automatic int escape_byte(input logic [7:0] ch);
      case (ch)
         "\\":    return 92;
         "n":     return 10;
         "t":     return 9;
         "r":     return 13;
         "b":     return 8;
         "f":     return 12;
         "v":     return 11;
         "a":     return 7;
         "'":     return 39;
         "\"":    return 34;
         default: return -1;
      endcase
   endfunction

   function automatic void add_result_byte(input logic [7:0] ch, input logic valid,
                                           input logic [1:0] st, input logic done);
      rsp_type r;
      if (step_results.size() < 2) begin
         r = '{char_out: ch, char_valid: valid, status: st, string_done: done, run_last: 1'b0};
         step_results.push_back(r);
      end
   endfunction

   function automatic void clear_decoder();
      dec_mode   = MODE_NORMAL;
      dec_value  = '0;
      dec_digits = '0;
      dec_error  = STATUS_OK;
   endfunction

   // decode one accepted byte and queue the bytes it should produce
   function automatic void decode_byte(input req_type item);
      logic [7:0]  ch;
      logic        digit;
      logic        plain;
      logic [11:0] sum;
      int          esc;
      ch    = item.char_in;
      digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      plain = 1'b0;
      case (dec_mode)
         MODE_NORMAL: begin
            plain = 1'b1;
         end
         MODE_ESCAPE: begin
            esc = escape_byte(ch);
            if (digit) begin
               dec_value  = ch - CHAR_ZERO;
               dec_digits = 2'd1;
               dec_mode   = MODE_DECIMAL;
               if (dec_digits >= MAX_DIGITS) begin
                  add_result_byte(dec_value, 1'b1, STATUS_OK, 1'b0);
                  dec_mode   = MODE_NORMAL;
                  dec_digits = '0;
               end
            end else if (esc >= 0) begin
               add_result_byte(8'(esc), 1'b1, STATUS_OK, 1'b0);
               dec_mode = MODE_NORMAL;
            end else begin
               dec_mode  = MODE_ERROR;
               dec_error = STATUS_BAD_ESCAPE;
            end
         end
         MODE_DECIMAL: begin
            if (digit) begin
               sum = 12'(dec_value) * 12'd10 + 12'(ch - CHAR_ZERO);
               if (sum > BYTE_MAX) begin
                  dec_mode  = MODE_ERROR;
                  dec_error = STATUS_OVERFLOW;
               end else begin
                  dec_value  = sum[7:0];
                  dec_digits = dec_digits + 2'd1;
                  if (dec_digits >= MAX_DIGITS) begin
                     add_result_byte(dec_value, 1'b1, STATUS_OK, 1'b0);
                     dec_mode   = MODE_NORMAL;
                     dec_digits = '0;
                  end
               end
            end else begin
               // ending byte flushes the value, then counts as an ordinary byte
               add_result_byte(dec_value, 1'b1, STATUS_OK, 1'b0);
               dec_mode   = MODE_NORMAL;
               dec_digits = '0;
               plain      = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (plain) begin
         if (ch == CHAR_BACKSLASH) dec_mode = MODE_ESCAPE;
         else add_result_byte(ch, 1'b1, STATUS_OK, 1'b0);
      end

      // end of string: exactly one result carries string_done
      if (item.end_of_string) begin
         if (dec_mode == MODE_DECIMAL) begin
            add_result_byte(dec_value, 1'b1, STATUS_OK, 1'b1);
         end else if (dec_mode == MODE_ESCAPE) begin
            add_result_byte(8'h00, 1'b0, STATUS_BAD_ESCAPE, 1'b1);
         end else if (dec_mode == MODE_ERROR) begin
            add_result_byte(8'h00, 1'b0, dec_error, 1'b1);
         end else if (step_results.size() == 0) begin
            add_result_byte(8'h00, 1'b0, STATUS_OK, 1'b1);
         end else begin
            step_results[step_results.size() - 1].string_done = 1'b1;
         end
         clear_decoder();
      end

      if (step_results.size() != 0) step_results[step_results.size() - 1].run_last = 1'b1;
      foreach (step_results[i]) expected_chars.push_back(step_results[i]);
      step_results.delete();
   endfunction

   function automatic void push_byte(input logic [7:0] ch, input logic ends);
      pending_bytes.push_back('{char_in: ch, end_of_string: ends});
   endfunction

   function automatic void queue_text(input string s, input logic ends);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], ends && (i == s.len() - 1));
   endfunction

   // one string of random pieces: plain bytes, well-formed escapes, some errors and noise
   function automatic void add_random_string();
      logic [7:0] body [$];
      logic [7:0] ch;
      int         kind;
      int         val;
      int         ndig;
      repeat ($urandom_range(1, 6)) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            do ch = 8'($urandom_range(255)); while (ch == CHAR_BACKSLASH);
            body.push_back(ch);
         end else if (kind < 55) begin
            body.push_back(CHAR_BACKSLASH);
            body.push_back(ESC_LETTERS[$urandom_range(9)]);
         end else if (kind < 80) begin
            // decimal escape, in range or overflowing
            ndig = (kind < 75) ? $urandom_range(1, 3) : 3;
            if (kind >= 75) val = $urandom_range(256, 999);
            else val = $urandom_range(0, (ndig == 1) ? 9 : (ndig == 2) ? 99 : 255);
            body.push_back(CHAR_BACKSLASH);
            if (ndig == 3) body.push_back(CHAR_ZERO + 8'(val / 100));
            if (ndig >= 2) body.push_back(CHAR_ZERO + 8'((val / 10) % 10));
            body.push_back(CHAR_ZERO + 8'(val % 10));
         end else if (kind < 85) begin
            do ch = 8'($urandom_range(255));
            while ((ch >= CHAR_ZERO && ch <= CHAR_NINE) || escape_byte(ch) >= 0);
            body.push_back(CHAR_BACKSLASH);
            body.push_back(ch);
         end else begin
            body.push_back(8'($urandom_range(255)));
         end
      end
      if ($urandom_range(19) == 0) body.push_back(CHAR_BACKSLASH);
      foreach (body[i]) push_byte(body[i], i == body.size() - 1);
   endfunction

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_chars.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int count);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      while (pending_bytes.size() < count) add_random_string();
      wait_drained();
   endtask

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predict on each input transaction, check each result transaction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         clear_decoder();
      end else begin
         if (req_valid && !req_stall) decode_byte(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected result, actual %p", $time, rsp_data);
               errors++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.char_out !== want.char_out) begin
                  $display("%0t: char_out expected %0h actual %0h", $time,
                           want.char_out, rsp_data.char_out);
                  errors++;
               end
               if (rsp_data.char_valid !== want.char_valid) begin
                  $display("%0t: char_valid expected %0b actual %0b", $time,
                           want.char_valid, rsp_data.char_valid);
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.string_done !== want.string_done) begin
                  $display("%0t: string_done expected %0b actual %0b", $time,
                           want.string_done, rsp_data.string_done);
                  errors++;
               end
               if (rsp_data.run_last !== want.run_last) begin
                  $display("%0t: run_last expected %0b actual %0b", $time,
                           want.run_last, rsp_data.run_last);
                  errors++;
               end
            end
         end
         // long hold-off once requested, random stalls otherwise
         if (long_hold && hold_count < LONG_HOLD_CYCLES) begin
            rsp_stall  <= 1'b1;
            hold_count <= hold_count + 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // stimulus sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed strings: byte extremes, letter escapes, decimal and error cases
      @(negedge clock);
      push_byte(8'h00, 1'b0);
      queue_text("\\n\\\\\\\"\\65", 1'b0);
      push_byte(8'hFF, 1'b1);
      queue_text("\\2557", 1'b1);
      queue_text("\\42", 1'b1);
      queue_text("\\256x", 1'b1);
      queue_text("\\qz", 1'b1);
      queue_text("\\", 1'b1);
      wait_drained();

      run_phase(0, 0, 200);
      run_phase(76, 0, 200);
      run_phase(0, 76, 200);
      run_phase(9, 9, 200);

      // receiver holds off while the sender keeps offering bytes
      @(negedge clock);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      long_hold      = 1'b1;
      while (pending_bytes.size() < 120) add_random_string();
      wait_drained();

      repeat (10) @(posedge clock);
      if (errors == 0 && expected_chars.size() == 0) begin
         $display("[string_escape_decoder] OK");
      end else begin
         $display("[string_escape_decoder] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("%0t: timeout with %0d results outstanding", $time, expected_chars.size());
      $display("[string_escape_decoder] ERROR");
      $finish;
   end

endmodule

/* files.f */
design/sed_pkg.sv
design/sed_decode.sv
design/string_escape_decoder.sv
sim/tb.sv
